### sv/evps_pkg.sv
// Shared types, codes and saturating fixed-point helpers for the velocity
// predictor stencil. Used by the interfaces, the divider, the lane and the top level.
`default_nettype none
package evps_pkg;

  typedef logic signed [31:0] q_t;

  typedef struct packed {
    logic sat;
    q_t   val;
  } qs_t;

  typedef struct packed {
    q_t c;
    q_t e;
    q_t w;
    q_t n;
    q_t s;
    q_t uc;
    q_t vc;
    q_t xn_m;
    q_t xn_0;
    q_t xn_p;
    q_t xc_0;
    q_t xc_p;
    q_t yn_m;
    q_t yn_0;
    q_t yn_p;
    q_t yc_m;
    q_t yc_0;
    q_t yc_p;
  } lane_in_t;

  localparam int IDX_W     = 6;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_RE    = 1'd1;

  localparam logic [CFG_W-1:0] TIME_STEP_RST = 31'd16777;
  localparam logic [CFG_W-1:0] INV_RE_RST    = 31'd167772;

  localparam logic [1:0] ACT_LOAD_CELL  = 2'd0;
  localparam logic [1:0] ACT_LOAD_COORD = 2'd1;
  localparam logic [1:0] ACT_COMPUTE    = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_EDGE = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_EDGE = 2'd1;
  localparam logic [1:0] KIND_CALC = 2'd2;

  localparam int DIV_STAGES = 8;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_LAT    = DIV_STAGES + 1;
  localparam int LANE_LAT   = 11 + 2 * DIV_LAT;

  localparam logic signed [63:0] Q_MAX64 = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] Q_MIN64 = 64'shFFFF_FFFF_8000_0000;
  localparam q_t Q_MAX = 32'sh7FFF_FFFF;
  localparam q_t Q_MIN = 32'sh8000_0000;

  function automatic qs_t clamp_q(input logic signed [63:0] x);
    qs_t r;
    if (x > Q_MAX64) begin
      r.sat = 1'b1;
      r.val = Q_MAX;
    end else if (x < Q_MIN64) begin
      r.sat = 1'b1;
      r.val = Q_MIN;
    end else begin
      r.sat = 1'b0;
      r.val = x[31:0];
    end
    return r;
  endfunction

  function automatic qs_t q_add(input q_t a, input q_t b);
    return clamp_q(64'(a) + 64'(b));
  endfunction

  function automatic qs_t q_sub(input q_t a, input q_t b);
    return clamp_q(64'(a) - 64'(b));
  endfunction

endpackage
`default_nettype wire

### sv/evps_ifs.sv
// Request and result channel interfaces of the velocity predictor stencil.
// Depends on evps_pkg for the fixed-point payload type.
`default_nettype none
interface evps_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [5:0]        col_index;
  logic [5:0]        row_index;
  evps_pkg::q_t      u_value;
  evps_pkg::q_t      v_value;
  evps_pkg::q_t      x_node;
  evps_pkg::q_t      x_centre;
  evps_pkg::q_t      y_node;
  evps_pkg::q_t      y_centre;

  modport source (output valid, action, col_index, row_index, u_value, v_value,
                  x_node, x_centre, y_node, y_centre, input ready);
  modport sink (input valid, action, col_index, row_index, u_value, v_value,
                x_node, x_centre, y_node, y_centre, output ready);
endinterface

interface evps_out_if;
  logic         valid;
  logic         ready;
  evps_pkg::q_t u_predicted;
  evps_pkg::q_t v_predicted;
  logic [1:0]   status;

  modport source (output valid, u_predicted, v_predicted, status, input ready);
  modport sink (input valid, u_predicted, v_predicted, status, output ready);
endinterface
`default_nettype wire

### sv/explicit_velocity_predictor_stencil.sv
// Velocity predictor stencil on a stretched 2-D mesh: one explicit Euler step of
// advection plus diffusion for an interior cell, from stored u, v and coordinates.
// Requests arrive on in_ch (valid/ready); each request gives exactly one result on
// out_ch in request order. Load requests write the velocity grids or the coordinate
// tables; a compute request names cell (col_index, row_index).
// Loads and edge computes pass the fetch stage in a single phase, so they are taken
// one per cycle while out_ch does not stall. An interior compute steps through
// phases PH_0, PH_1 and PH_LAST there, since the ten velocity neighbours come from
// two-read-port grid memories and the coordinates from one-read-port tables. Each
// result passes a 29-stage arithmetic pipeline with two ranks of 9-stage dividers.
// Reset sets time_step and inverse_reynolds to their defaults and empties the
// pipeline; the grids and tables hold nothing defined until written.
// When out_ch.ready is low with a result waiting, the whole pipeline holds and
// in_ch.ready drops; nothing is lost or repeated.
// Depends on evps_pkg, evps_ifs, evps_lane and evps_div.
`default_nettype none
module explicit_velocity_predictor_stencil #(
  parameter int GRID_X    = 64,
  parameter int GRID_Y    = 64,
  parameter int FRAC_BITS = 24
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  evps_in_if.sink                              in_ch,
  evps_out_if.source                           out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [evps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [evps_pkg::CFG_W-1:0]      cfg_wdata
);
  import evps_pkg::*;

  localparam int XW    = $clog2(GRID_X);
  localparam int YW    = $clog2(GRID_Y);
  localparam int CELLS = GRID_X * GRID_Y;
  localparam int CW    = $clog2(CELLS);

  localparam logic [1:0] PH_0    = 2'd0;
  localparam logic [1:0] PH_1    = 2'd1;
  localparam logic [1:0] PH_LAST = 2'd2;

  logic [CFG_W-1:0] time_step_r, inv_re_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r <= TIME_STEP_RST;
      inv_re_r    <= INV_RE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TIME_STEP: time_step_r <= cfg_wdata;
        REG_INV_RE:    inv_re_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic out_valid_r;
  logic en;
  assign en = !out_valid_r || out_ch.ready;

  // Fetch stage: holds one request and issues its memory reads.
  logic             hold_vld_r;
  logic [1:0]       h_act_r;
  logic [IDX_W-1:0] h_i_r, h_j_r;
  q_t               h_uval_r, h_vval_r, h_xn_r, h_xc_r, h_yn_r, h_yc_r;
  logic [1:0]       ph_r;

  int         ci, cj, ai, aj, bi, bj;
  logic       interior, h_last;
  logic [1:0] h_kind;
  logic       wr_cell, wr_x, wr_y, rd;

  always_comb begin
    ci = int'(h_i_r);
    cj = int'(h_j_r);
    interior = (h_act_r == ACT_COMPUTE) && (ci != 0) && (cj != 0)
               && (ci < GRID_X - 1) && (cj < GRID_Y - 1);
    h_last = !interior || (ph_r == PH_LAST);
    if (h_act_r == ACT_COMPUTE) begin
      h_kind = interior ? KIND_CALC : KIND_EDGE;
    end else begin
      h_kind = KIND_NONE;
    end
    unique case (ph_r)
      PH_0: begin
        ai = ci;     aj = cj;
        bi = ci + 1; bj = cj;
      end
      PH_1: begin
        ai = ci - 1; aj = cj;
        bi = ci;     bj = cj + 1;
      end
      default: begin
        ai = ci;     aj = cj - 1;
        bi = ci;     bj = cj + 1;
      end
    endcase
    wr_cell = hold_vld_r && (h_act_r == ACT_LOAD_CELL) && (ci < GRID_X) && (cj < GRID_Y);
    wr_x    = hold_vld_r && (h_act_r == ACT_LOAD_COORD) && (ci < GRID_X);
    wr_y    = hold_vld_r && (h_act_r == ACT_LOAD_COORD) && (cj < GRID_Y);
    rd      = hold_vld_r && interior;
  end

  assign in_ch.ready = en && (!hold_vld_r || h_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
      ph_r       <= PH_0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        hold_vld_r <= 1'b1;
      end else if (en && h_last) begin
        hold_vld_r <= 1'b0;
      end
      if (en && rd) begin
        ph_r <= h_last ? PH_0 : ph_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      h_act_r  <= in_ch.action;
      h_i_r    <= in_ch.col_index;
      h_j_r    <= in_ch.row_index;
      h_uval_r <= in_ch.u_value;
      h_vval_r <= in_ch.v_value;
      h_xn_r   <= in_ch.x_node;
      h_xc_r   <= in_ch.x_centre;
      h_yn_r   <= in_ch.y_node;
      h_yc_r   <= in_ch.y_centre;
    end
  end

  // Stores.
  q_t u_mem  [0:CELLS-1];
  q_t v_mem  [0:CELLS-1];
  q_t xn_mem [0:GRID_X-1];
  q_t xc_mem [0:GRID_X-1];
  q_t yn_mem [0:GRID_Y-1];
  q_t yc_mem [0:GRID_Y-1];

  logic [CW-1:0] wa, ra, rb;
  logic [XW-1:0] wx, rx;
  logic [YW-1:0] wy, ry;

  always_comb begin
    wa = CW'(ci * GRID_Y + cj);
    ra = CW'(ai * GRID_Y + aj);
    rb = CW'(bi * GRID_Y + bj);
    wx = XW'(ci);
    wy = YW'(cj);
    rx = XW'(ci - 1 + int'(ph_r));
    ry = YW'(cj - 1 + int'(ph_r));
  end

  q_t ua_r, ub_r, va_r, vb_r, xn_r, xc_r, yn_r, yc_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (wr_cell) begin
        u_mem[wa] <= h_uval_r;
        v_mem[wa] <= h_vval_r;
      end
      if (wr_x) begin
        xn_mem[wx] <= h_xn_r;
        xc_mem[wx] <= h_xc_r;
      end
      if (wr_y) begin
        yn_mem[wy] <= h_yn_r;
        yc_mem[wy] <= h_yc_r;
      end
      if (rd) begin
        ua_r <= u_mem[ra];
        ub_r <= u_mem[rb];
        va_r <= v_mem[ra];
        vb_r <= v_mem[rb];
        xn_r <= xn_mem[rx];
        xc_r <= xc_mem[rx];
        yn_r <= yn_mem[ry];
        yc_r <= yc_mem[ry];
      end
    end
  end

  // Read-return stage and operand assembly.
  logic       b_rd_r, b_launch_r;
  logic [1:0] b_ph_r, b_kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_rd_r     <= 1'b0;
      b_launch_r <= 1'b0;
      b_ph_r     <= PH_0;
      b_kind_r   <= KIND_NONE;
    end else if (en) begin
      b_rd_r     <= rd;
      b_launch_r <= hold_vld_r && h_last;
      b_ph_r     <= ph_r;
      b_kind_r   <= h_kind;
    end
  end

  q_t uc_s, ue_s, uw_s, un_s, vc_s, ve_s, vw_s, vn_s;
  q_t xn_m_s, xn_0_s, xc_0_s, yn_m_s, yn_0_s, yc_m_s, yc_0_s;

  always_ff @(posedge clk) begin
    if (en && b_rd_r) begin
      unique case (b_ph_r)
        PH_0: begin
          uc_s <= ua_r; ue_s <= ub_r; vc_s <= va_r; ve_s <= vb_r;
          xn_m_s <= xn_r; yn_m_s <= yn_r; yc_m_s <= yc_r;
        end
        PH_1: begin
          uw_s <= ua_r; un_s <= ub_r; vw_s <= va_r; vn_s <= vb_r;
          xn_0_s <= xn_r; xc_0_s <= xc_r; yn_0_s <= yn_r; yc_0_s <= yc_r;
        end
        default: ;
      endcase
    end
  end

  lane_in_t lu, lv;

  always_comb begin
    lu.c = uc_s; lu.e = ue_s; lu.w = uw_s; lu.n = un_s; lu.s = ua_r;
    lu.uc = uc_s; lu.vc = vc_s;
    lu.xn_m = xn_m_s; lu.xn_0 = xn_0_s; lu.xn_p = xn_r;
    lu.xc_0 = xc_0_s; lu.xc_p = xc_r;
    lu.yn_m = yn_m_s; lu.yn_0 = yn_0_s; lu.yn_p = yn_r;
    lu.yc_m = yc_m_s; lu.yc_0 = yc_0_s; lu.yc_p = yc_r;
    lv = lu;
    lv.c = vc_s; lv.e = ve_s; lv.w = vw_s; lv.n = vn_s; lv.s = va_r;
  end

  q_t   u_res, v_res;
  logic u_sat, v_sat;

  evps_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_u (
    .clk, .en, .din(lu), .time_step(time_step_r), .inv_re(inv_re_r),
    .w_pred(u_res), .sat(u_sat)
  );

  evps_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_v (
    .clk, .en, .din(lv), .time_step(time_step_r), .inv_re(inv_re_r),
    .w_pred(v_res), .sat(v_sat)
  );

  logic       vp_r [0:LANE_LAT-1];
  logic [1:0] kp_r [0:LANE_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LANE_LAT; k++) begin
        vp_r[k] <= 1'b0;
        kp_r[k] <= KIND_NONE;
      end
    end else if (en) begin
      vp_r[0] <= b_launch_r;
      kp_r[0] <= b_kind_r;
      for (int k = 1; k < LANE_LAT; k++) begin
        vp_r[k] <= vp_r[k-1];
        kp_r[k] <= kp_r[k-1];
      end
    end
  end

  q_t         out_u_r, out_v_r;
  logic [1:0] out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vp_r[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unique case (kp_r[LANE_LAT-1])
        KIND_CALC: begin
          out_u_r      <= u_res;
          out_v_r      <= v_res;
          out_status_r <= (u_sat || v_sat) ? ST_SAT : ST_OK;
        end
        KIND_EDGE: begin
          out_u_r      <= '0;
          out_v_r      <= '0;
          out_status_r <= ST_EDGE;
        end
        default: begin
          out_u_r      <= '0;
          out_v_r      <= '0;
          out_status_r <= ST_OK;
        end
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.u_predicted = out_u_r;
  assign out_ch.v_predicted = out_v_r;
  assign out_ch.status      = out_status_r;

endmodule
`default_nettype wire

### sv/evps_div.sv
// Pipelined saturating Q-format divider: (num * 2^FRAC_BITS) / den, truncated.
// Depends on evps_pkg; one division per cycle while en is high.
`default_nettype none
module evps_div #(
  parameter int FRAC_BITS = 24
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire evps_pkg::q_t num,
  input  wire evps_pkg::q_t den,
  output evps_pkg::q_t      quo,
  output logic              sat
);
  import evps_pkg::*;

  localparam int NW = 32 + FRAC_BITS;

  typedef struct packed {
    logic zero;
    logic ovf;
    logic neg;
    logic num_pos;
    logic num_neg;
  } dflag_t;

  logic [32:0] rem_r [0:DIV_STAGES];
  logic [31:0] lo_r  [0:DIV_STAGES];
  logic [31:0] q_r   [0:DIV_STAGES];
  logic [31:0] ad_r  [0:DIV_STAGES];
  dflag_t      fl_r  [0:DIV_STAGES];

  logic [32:0] rem_nxt [1:DIV_STAGES];
  logic [31:0] lo_nxt  [1:DIV_STAGES];
  logic [31:0] q_nxt   [1:DIV_STAGES];

  logic [31:0]    an;
  logic [31:0]    ad;
  logic [NW-1:0]  nf;
  logic [FRAC_BITS-1:0] hi;
  dflag_t         fl0;

  always_comb begin
    an = num[31] ? 32'(-num) : 32'(num);
    ad = den[31] ? 32'(-den) : 32'(den);
    nf = {an, {FRAC_BITS{1'b0}}};
    hi = nf[NW-1:32];
    fl0.zero    = (den == '0);
    fl0.ovf     = (32'(hi) >= ad);
    fl0.neg     = num[31] ^ den[31];
    fl0.num_pos = !num[31] && (num != '0);
    fl0.num_neg = num[31];
  end

  always_comb begin
    logic [32:0] r;
    logic [31:0] l;
    logic [31:0] q;
    for (int k = 1; k <= DIV_STAGES; k++) begin
      r = rem_r[k-1];
      l = lo_r[k-1];
      q = q_r[k-1];
      for (int s = 0; s < DIV_STEPS; s++) begin
        r = {r[31:0], l[31]};
        l = {l[30:0], 1'b0};
        if (r >= {1'b0, ad_r[k-1]}) begin
          r = r - {1'b0, ad_r[k-1]};
          q = {q[30:0], 1'b1};
        end else begin
          q = {q[30:0], 1'b0};
        end
      end
      rem_nxt[k] = r;
      lo_nxt[k]  = l;
      q_nxt[k]   = q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= 33'(hi);
      lo_r[0]  <= nf[31:0];
      q_r[0]   <= '0;
      ad_r[0]  <= ad;
      fl_r[0]  <= fl0;
      for (int k = 1; k <= DIV_STAGES; k++) begin
        rem_r[k] <= rem_nxt[k];
        lo_r[k]  <= lo_nxt[k];
        q_r[k]   <= q_nxt[k];
        ad_r[k]  <= ad_r[k-1];
        fl_r[k]  <= fl_r[k-1];
      end
    end
  end

  dflag_t      fo;
  logic [31:0] qo;

  always_comb begin
    fo = fl_r[DIV_STAGES];
    qo = q_r[DIV_STAGES];
    if (fo.zero) begin
      sat = 1'b1;
      quo = fo.num_pos ? Q_MAX : (fo.num_neg ? Q_MIN : '0);
    end else if (fo.ovf) begin
      sat = 1'b1;
      quo = fo.neg ? Q_MIN : Q_MAX;
    end else if (!fo.neg) begin
      sat = qo[31];
      quo = qo[31] ? Q_MAX : q_t'(qo);
    end else begin
      sat = (qo > 32'h8000_0000);
      quo = sat ? Q_MIN : q_t'(-qo);
    end
  end

endmodule
`default_nettype wire

### sv/evps_lane.sv
// Arithmetic lane for one velocity component: differences, advection,
// diffusion and the Euler update. Depends on evps_pkg and evps_div.
`default_nettype none
module evps_lane #(
  parameter int FRAC_BITS = 24
) (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire evps_pkg::lane_in_t        din,
  input  wire logic [evps_pkg::CFG_W-1:0] time_step,
  input  wire logic [evps_pkg::CFG_W-1:0] inv_re,
  output evps_pkg::q_t                   w_pred,
  output logic                           sat
);
  import evps_pkg::*;

  typedef struct packed {
    q_t   c;
    q_t   dxc_p;
    q_t   dyc_m;
    logic sat;
  } d1_t;

  typedef struct packed {
    q_t   c;
    q_t   adv;
    logic sat;
  } d2_t;

  // Stage 1: differences and spacings.
  q_t de1_r, dw1_r, dn1_r, ds1_r, dxc_p1_r, dyc_p1_r, dyc_m1_r;
  q_t dx_p1_r, dx_m1_r, dy_p1_r, dy_m1_r, uc1_r, vc1_r, c1_r;
  logic sat1_r;
  qs_t de, dw, dn, ds, dxcp, dycp, dycm, dxp, dxm, dyp, dym;

  always_comb begin
    de   = q_sub(din.e, din.c);
    dw   = q_sub(din.c, din.w);
    dn   = q_sub(din.n, din.c);
    ds   = q_sub(din.c, din.s);
    dxcp = q_sub(din.xc_p, din.xc_0);
    dycp = q_sub(din.yc_p, din.yc_0);
    dycm = q_sub(din.yc_0, din.yc_m);
    dxp  = q_sub(din.xn_p, din.xn_0);
    dxm  = q_sub(din.xn_0, din.xn_m);
    dyp  = q_sub(din.yn_p, din.yn_0);
    dym  = q_sub(din.yn_0, din.yn_m);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      de1_r <= de.val;  dw1_r <= dw.val;  dn1_r <= dn.val;  ds1_r <= ds.val;
      dxc_p1_r <= dxcp.val; dyc_p1_r <= dycp.val; dyc_m1_r <= dycm.val;
      dx_p1_r <= dxp.val; dx_m1_r <= dxm.val; dy_p1_r <= dyp.val; dy_m1_r <= dym.val;
      uc1_r <= din.uc; vc1_r <= din.vc; c1_r <= din.c;
      sat1_r <= de.sat | dw.sat | dn.sat | ds.sat | dxcp.sat | dycp.sat | dycm.sat
                | dxp.sat | dxm.sat | dyp.sat | dym.sat;
    end
  end

  // Stage 2: advection products.
  logic signed [63:0] p1_r, p2_r;
  q_t de2_r, dw2_r, dn2_r, ds2_r, dxc_p2_r, dyc_p2_r, dyc_m2_r;
  q_t dx_p2_r, dx_m2_r, dy_p2_r, dy_m2_r, c2_r;
  logic sat2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r <= uc1_r * de1_r;
      p2_r <= vc1_r * dn1_r;
      de2_r <= de1_r; dw2_r <= dw1_r; dn2_r <= dn1_r; ds2_r <= ds1_r;
      dxc_p2_r <= dxc_p1_r; dyc_p2_r <= dyc_p1_r; dyc_m2_r <= dyc_m1_r;
      dx_p2_r <= dx_p1_r; dx_m2_r <= dx_m1_r; dy_p2_r <= dy_p1_r; dy_m2_r <= dy_m1_r;
      c2_r <= c1_r; sat2_r <= sat1_r;
    end
  end

  // Stage 3: product scaling.
  q_t a1n3_r, a2n3_r, de3_r, dw3_r, dn3_r, ds3_r, dxc_p3_r, dyc_p3_r, dyc_m3_r;
  q_t dx_p3_r, dx_m3_r, dy_p3_r, dy_m3_r, c3_r;
  logic sat3_r;
  qs_t pa1, pa2;

  always_comb begin
    pa1 = clamp_q(p1_r >>> FRAC_BITS);
    pa2 = clamp_q(p2_r >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1n3_r <= pa1.val; a2n3_r <= pa2.val;
      de3_r <= de2_r; dw3_r <= dw2_r; dn3_r <= dn2_r; ds3_r <= ds2_r;
      dxc_p3_r <= dxc_p2_r; dyc_p3_r <= dyc_p2_r; dyc_m3_r <= dyc_m2_r;
      dx_p3_r <= dx_p2_r; dx_m3_r <= dx_m2_r; dy_p3_r <= dy_p2_r; dy_m3_r <= dy_m2_r;
      c3_r <= c2_r; sat3_r <= sat2_r | pa1.sat | pa2.sat;
    end
  end

  // First divider rank.
  q_t   a1q, a2q, g1q, g2q, g3q, g4q;
  logic a1s, a2s, g1s, g2s, g3s, g4s;

  evps_div #(.FRAC_BITS(FRAC_BITS)) u_div_a1 (.clk, .en, .num(a1n3_r), .den(dxc_p3_r),
                                              .quo(a1q), .sat(a1s));
  evps_div #(.FRAC_BITS(FRAC_BITS)) u_div_a2 (.clk, .en, .num(a2n3_r), .den(dyc_p3_r),
                                              .quo(a2q), .sat(a2s));
  evps_div #(.FRAC_BITS(FRAC_BITS)) u_div_g1 (.clk, .en, .num(de3_r), .den(dx_p3_r),
                                              .quo(g1q), .sat(g1s));
  evps_div #(.FRAC_BITS(FRAC_BITS)) u_div_g2 (.clk, .en, .num(dw3_r), .den(dx_m3_r),
                                              .quo(g2q), .sat(g2s));
  evps_div #(.FRAC_BITS(FRAC_BITS)) u_div_g3 (.clk, .en, .num(dn3_r), .den(dy_p3_r),
                                              .quo(g3q), .sat(g3s));
  evps_div #(.FRAC_BITS(FRAC_BITS)) u_div_g4 (.clk, .en, .num(ds3_r), .den(dy_m3_r),
                                              .quo(g4q), .sat(g4s));

  d1_t d1_r [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r[0] <= '{c: c3_r, dxc_p: dxc_p3_r, dyc_m: dyc_m3_r, sat: sat3_r};
      for (int k = 1; k < DIV_LAT; k++) begin
        d1_r[k] <= d1_r[k-1];
      end
    end
  end

  // Stage 4: capture quotients.
  q_t a14_r, a24_r, g14_r, g24_r, g34_r, g44_r, c4_r, dxc_p4_r, dyc_m4_r;
  logic sat4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a14_r <= a1q; a24_r <= a2q; g14_r <= g1q; g24_r <= g2q; g34_r <= g3q; g44_r <= g4q;
      c4_r <= d1_r[DIV_LAT-1].c;
      dxc_p4_r <= d1_r[DIV_LAT-1].dxc_p;
      dyc_m4_r <= d1_r[DIV_LAT-1].dyc_m;
      sat4_r <= d1_r[DIV_LAT-1].sat | a1s | a2s | g1s | g2s | g3s | g4s;
    end
  end

  // Stage 5: advection sum and gradient differences.
  q_t adv5_r, gx5_r, gy5_r, c5_r, dxc_p5_r, dyc_m5_r;
  logic sat5_r;
  qs_t adv, gx, gy;

  always_comb begin
    adv = q_add(a14_r, a24_r);
    gx  = q_sub(g14_r, g24_r);
    gy  = q_sub(g34_r, g44_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      adv5_r <= adv.val; gx5_r <= gx.val; gy5_r <= gy.val;
      c5_r <= c4_r; dxc_p5_r <= dxc_p4_r; dyc_m5_r <= dyc_m4_r;
      sat5_r <= sat4_r | adv.sat | gx.sat | gy.sat;
    end
  end

  // Second divider rank.
  q_t   dxxq, dyyq;
  logic dxxs, dyys;

  evps_div #(.FRAC_BITS(FRAC_BITS)) u_div_xx (.clk, .en, .num(gx5_r), .den(dxc_p5_r),
                                              .quo(dxxq), .sat(dxxs));
  evps_div #(.FRAC_BITS(FRAC_BITS)) u_div_yy (.clk, .en, .num(gy5_r), .den(dyc_m5_r),
                                              .quo(dyyq), .sat(dyys));

  d2_t d2_r [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      d2_r[0] <= '{c: c5_r, adv: adv5_r, sat: sat5_r};
      for (int k = 1; k < DIV_LAT; k++) begin
        d2_r[k] <= d2_r[k-1];
      end
    end
  end

  // Stages 6 to 11: diffusion sum and Euler update.
  q_t dxx6_r, dyy6_r, c6_r, adv6_r;
  logic sat6_r;
  q_t diff7_r, c7_r, adv7_r;
  logic sat7_r;
  logic signed [63:0] m18_r;
  q_t c8_r, adv8_r;
  logic sat8_r;
  q_t rhs9_r, c9_r;
  logic sat9_r;
  logic signed [63:0] m210_r;
  q_t c10_r;
  logic sat10_r;
  q_t res11_r;
  logic sat11_r;

  q_t  ire_q, dt_q;
  qs_t diff, m1c, rhs, m2c, res;

  always_comb begin
    ire_q = $signed({1'b0, inv_re});
    dt_q  = $signed({1'b0, time_step});
    diff  = q_add(dxx6_r, dyy6_r);
    m1c   = clamp_q(m18_r >>> FRAC_BITS);
    rhs   = q_sub(m1c.val, adv8_r);
    m2c   = clamp_q(m210_r >>> FRAC_BITS);
    res   = q_add(c10_r, m2c.val);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dxx6_r <= dxxq; dyy6_r <= dyyq;
      c6_r <= d2_r[DIV_LAT-1].c; adv6_r <= d2_r[DIV_LAT-1].adv;
      sat6_r <= d2_r[DIV_LAT-1].sat | dxxs | dyys;

      diff7_r <= diff.val; c7_r <= c6_r; adv7_r <= adv6_r; sat7_r <= sat6_r | diff.sat;

      m18_r <= ire_q * diff7_r; c8_r <= c7_r; adv8_r <= adv7_r; sat8_r <= sat7_r;

      rhs9_r <= rhs.val; c9_r <= c8_r; sat9_r <= sat8_r | m1c.sat | rhs.sat;

      m210_r <= dt_q * rhs9_r; c10_r <= c9_r; sat10_r <= sat9_r;

      res11_r <= res.val; sat11_r <= sat10_r | m2c.sat | res.sat;
    end
  end

  assign w_pred = res11_r;
  assign sat    = sat11_r;

endmodule
`default_nettype wire

### tb/evps_predict_check.sv
// Passive checker for the velocity predictor stencil: watches the request,
// result and register ports, predicts each result and compares it.
// Depends on evps_pkg and the evps_in_if / evps_out_if interfaces.
module evps_predict_check (
  input  logic                            clk,
  input  logic                            rst_n,
  evps_in_if                              in_ch,
  evps_out_if                             out_ch,
  input  logic                            cfg_we,
  input  logic [evps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [evps_pkg::CFG_W-1:0]      cfg_wdata,
  output int                              failures,
  output int                              pending
);
  import evps_pkg::*;

  localparam int FRAC = 24;
  localparam int NX = 64;
  localparam int NY = 64;
  localparam longint HI = 64'sd2147483647;
  localparam longint LO = -64'sd2147483648;

  typedef struct {
    q_t         u;
    q_t         v;
    logic [1:0] st;
  } velocity_result_t;

  velocity_result_t expected_q[$];
  q_t u_mem [NX*NY];
  q_t v_mem [NX*NY];
  q_t xn_mem [NX];
  q_t xc_mem [NX];
  q_t yn_mem [NY];
  q_t yc_mem [NY];
  logic [CFG_W-1:0] dt;
  logic [CFG_W-1:0] inv_re;
  bit sat_hit;

  initial begin
    failures = 0;
    pending = 0;
  end

  function automatic longint sat_q(longint x);
    if (x > HI) begin
      sat_hit = 1;
      return HI;
    end
    if (x < LO) begin
      sat_hit = 1;
      return LO;
    end
    return x;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return sat_q((a * b) >>> FRAC);
  endfunction

  function automatic longint fx_div(longint n, longint d);
    if (d == 0) begin
      sat_hit = 1;
      return (n > 0) ? HI : ((n < 0) ? LO : 0);
    end
    return sat_q((n <<< FRAC) / d);
  endfunction

  function automatic longint vel_at(bit use_v, int i, int j);
    return use_v ? longint'(v_mem[i*NY+j]) : longint'(u_mem[i*NY+j]);
  endfunction

  function automatic longint predict_vel(bit use_v, int i, int j);
    longint uc, vc, c, de, dw, dn, ds;
    longint dxc_p, dyc_p, dyc_m, dx_p, dx_m, dy_p, dy_m;
    longint a1, a2, adv, gx, dxx, gy, dyy, diff, rhs;
    uc = vel_at(0, i, j);
    vc = vel_at(1, i, j);
    c = vel_at(use_v, i, j);
    de = sat_q(vel_at(use_v, i+1, j) - c);
    dw = sat_q(c - vel_at(use_v, i-1, j));
    dn = sat_q(vel_at(use_v, i, j+1) - c);
    ds = sat_q(c - vel_at(use_v, i, j-1));
    dxc_p = sat_q(longint'(xc_mem[i+1]) - xc_mem[i]);
    dyc_p = sat_q(longint'(yc_mem[j+1]) - yc_mem[j]);
    dyc_m = sat_q(longint'(yc_mem[j]) - yc_mem[j-1]);
    dx_p = sat_q(longint'(xn_mem[i+1]) - xn_mem[i]);
    dx_m = sat_q(longint'(xn_mem[i]) - xn_mem[i-1]);
    dy_p = sat_q(longint'(yn_mem[j+1]) - yn_mem[j]);
    dy_m = sat_q(longint'(yn_mem[j]) - yn_mem[j-1]);
    a1 = fx_div(fx_mul(uc, de), dxc_p);
    a2 = fx_div(fx_mul(vc, dn), dyc_p);
    adv = sat_q(a1 + a2);
    gx = sat_q(fx_div(de, dx_p) - fx_div(dw, dx_m));
    dxx = fx_div(gx, dxc_p);
    gy = sat_q(fx_div(dn, dy_p) - fx_div(ds, dy_m));
    dyy = fx_div(gy, dyc_m);
    diff = sat_q(dxx + dyy);
    rhs = sat_q(fx_mul(longint'(inv_re), diff) - adv);
    return sat_q(c + fx_mul(longint'(dt), rhs));
  endfunction

  task automatic report(input string msg);
    failures++;
    if (failures <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    velocity_result_t r;
    longint up, vp;
    int i, j;
    if (!rst_n) begin
      expected_q.delete();
      dt = TIME_STEP_RST;
      inv_re = INV_RE_RST;
      pending = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TIME_STEP: dt = cfg_wdata;
          REG_INV_RE: inv_re = cfg_wdata;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          report($sformatf("Unexpected result u=%h v=%h status=%0d",
                           out_ch.u_predicted, out_ch.v_predicted, out_ch.status));
        end else begin
          r = expected_q.pop_front();
          if (r.u !== out_ch.u_predicted || r.v !== out_ch.v_predicted ||
              r.st !== out_ch.status)
            report($sformatf("Mismatch: expected u=%h v=%h status=%0d, got u=%h v=%h status=%0d",
                             r.u, r.v, r.st, out_ch.u_predicted, out_ch.v_predicted,
                             out_ch.status));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        i = in_ch.col_index;
        j = in_ch.row_index;
        r.u = '0;
        r.v = '0;
        r.st = ST_OK;
        case (in_ch.action)
          ACT_LOAD_CELL: begin
            u_mem[i*NY+j] = in_ch.u_value;
            v_mem[i*NY+j] = in_ch.v_value;
          end
          ACT_LOAD_COORD: begin
            xn_mem[i] = in_ch.x_node;
            xc_mem[i] = in_ch.x_centre;
            yn_mem[j] = in_ch.y_node;
            yc_mem[j] = in_ch.y_centre;
          end
          ACT_COMPUTE: begin
            if (i == 0 || j == 0 || i >= NX-1 || j >= NY-1) begin
              r.st = ST_EDGE;
            end else begin
              sat_hit = 0;
              up = predict_vel(0, i, j);
              vp = predict_vel(1, i, j);
              r.u = up[31:0];
              r.v = vp[31:0];
              r.st = sat_hit ? ST_SAT : ST_OK;
            end
          end
          default: ;
        endcase
        expected_q.push_back(r);
      end
      pending = expected_q.size();
    end
  end
endmodule

### tb/explicit_velocity_predictor_stencil_tb.sv
// Top of the velocity predictor stencil bench: clock, reset, register writes,
// request stimulus and result back-pressure, plus the final verdict.
// Depends on evps_pkg, the channel interfaces, the block and evps_predict_check.
module explicit_velocity_predictor_stencil_tb;
  import evps_pkg::*;

  localparam int LIMIT = 400000;
  localparam int DRAIN = 60;
  localparam logic [1:0] ACT_SPARE = 2'd3;

  typedef struct {
    logic [1:0] act;
    logic [5:0] ci;
    logic [5:0] ri;
    q_t         uv;
    q_t         vv;
    q_t         xn;
    q_t         xc;
    q_t         yn;
    q_t         yc;
  } stencil_req_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  int failures;
  int pending;
  int cycles = 0;
  int hold_len = 0;
  bit no_idle = 0;
  bit cell_w [4096];
  bit x_w [64];
  bit y_w [64];
  int fi, fj;

  evps_in_if in_ch ();
  evps_out_if out_ch ();

  explicit_velocity_predictor_stencil u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  evps_predict_check u_check (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .failures(failures), .pending(pending)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // The receiver stalls at random and honors long hold-offs requested by the stimulus.
  initial begin
    int g;
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        out_ch.ready = 0;
        repeat (hold_len) @(negedge clk);
        hold_len = 0;
      end
      g = gap_len();
      if (g > 0) begin
        out_ch.ready = 0;
        repeat (g - 1) @(negedge clk);
      end else begin
        out_ch.ready = 1;
      end
    end
  end

  function automatic q_t node_at(int k);
    return q_t'(k * (1 << 22) + k * k * (1 << 16));
  endfunction

  function automatic q_t centre_at(int k);
    return q_t'(node_at(k) + (1 << 21) + k * (1 << 15));
  endfunction

  function automatic q_t rand_vel();
    if ($urandom_range(4) == 0) return q_t'($urandom);
    return q_t'($urandom_range(1 << 27) - (1 << 26));
  endfunction

  function automatic stencil_req_t cell_req(int i, int j, q_t u, q_t v);
    stencil_req_t s;
    s.act = ACT_LOAD_CELL;
    s.ci = 6'(i);
    s.ri = 6'(j);
    s.uv = u;
    s.vv = v;
    s.xn = $urandom;
    s.xc = $urandom;
    s.yn = $urandom;
    s.yc = $urandom;
    return s;
  endfunction

  function automatic stencil_req_t coord_req(int i, int j, q_t xn, q_t xc, q_t yn, q_t yc);
    stencil_req_t s;
    s = cell_req(i, j, $urandom, $urandom);
    s.act = ACT_LOAD_COORD;
    s.xn = xn;
    s.xc = xc;
    s.yn = yn;
    s.yc = yc;
    return s;
  endfunction

  function automatic stencil_req_t calc_req(int i, int j);
    stencil_req_t s;
    s = cell_req(i, j, $urandom, $urandom);
    s.act = ACT_COMPUTE;
    return s;
  endfunction

  function automatic bit ready_to_compute(int i, int j);
    if (i < 1 || j < 1 || i > 62 || j > 62) return 0;
    return cell_w[i*64+j] && cell_w[(i+1)*64+j] && cell_w[(i-1)*64+j] &&
           cell_w[i*64+j+1] && cell_w[i*64+j-1] && x_w[i-1] && x_w[i] &&
           x_w[i+1] && y_w[j-1] && y_w[j] && y_w[j+1];
  endfunction

  task automatic send(input stencil_req_t s);
    int g;
    in_ch.valid = 1;
    in_ch.action = s.act;
    in_ch.col_index = s.ci;
    in_ch.row_index = s.ri;
    in_ch.u_value = s.uv;
    in_ch.v_value = s.vv;
    in_ch.x_node = s.xn;
    in_ch.x_centre = s.xc;
    in_ch.y_node = s.yn;
    in_ch.y_centre = s.yc;
    if (s.act == ACT_LOAD_CELL) cell_w[s.ci*64+s.ri] = 1;
    if (s.act == ACT_LOAD_COORD) begin
      x_w[s.ci] = 1;
      y_w[s.ri] = 1;
    end
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    g = gap_len();
    if (g > 0) begin
      in_ch.valid = 0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic set_cfg(input logic [CFG_W-1:0] ts, input logic [CFG_W-1:0] ir);
    cfg_we = 1;
    cfg_index = REG_TIME_STEP;
    cfg_wdata = ts;
    @(negedge clk);
    cfg_index = REG_INV_RE;
    cfg_wdata = ir;
    @(negedge clk);
    cfg_we = 0;
  endtask

  function automatic int near(int f);
    int k;
    k = f + $urandom_range(4) - 2;
    return (k < 0) ? 0 : ((k > 63) ? 63 : k);
  endfunction

  task automatic random_item();
    int r, i, j, k, m;
    q_t xn, xc, yn, yc;
    stencil_req_t s;
    r = $urandom_range(99);
    i = near(fi);
    j = near(fj);
    if (r < 45) begin
      send(cell_req(i, j, rand_vel(), rand_vel()));
    end else if (r < 82) begin
      if (ready_to_compute(i, j) || i == 0 || j == 0 || i == 63 || j == 63)
        send(calc_req(i, j));
      else
        send(cell_req(i, j, rand_vel(), rand_vel()));
    end else if (r < 92) begin
      k = $urandom_range(63);
      m = $urandom_range(63);
      r = $urandom_range(9);
      xn = node_at(k) + $urandom_range(4095);
      xc = centre_at(k) + $urandom_range(4095);
      yn = node_at(m) + $urandom_range(4095);
      yc = centre_at(m) + $urandom_range(4095);
      if (r < 2) begin
        xn = (k > 0) ? node_at(k - 1) : node_at(k);
        yc = (m > 0) ? centre_at(m - 1) : centre_at(m);
      end else if (r < 4) begin
        xn = $urandom;
        xc = $urandom;
        yn = $urandom;
        yc = $urandom;
      end
      send(coord_req(k, m, xn, xc, yn, yc));
    end else if (r < 95) begin
      send(cell_req($urandom_range(63), $urandom_range(63), $urandom, $urandom));
      send(calc_req($urandom_range(1) ? 0 : 63, $urandom_range(63)));
    end else if (r < 97) begin
      send(calc_req($urandom_range(63), $urandom_range(1) ? 0 : 63));
    end else begin
      send(cell_req($urandom_range(63), $urandom_range(63), $urandom, $urandom));
      s = calc_req($urandom_range(63), $urandom_range(63));
      s.act = ACT_SPARE;
      send(s);
    end
  endtask

  task automatic random_phase(input int count, input int phase);
    int n;
    for (n = 0; n < count; n++) begin
      if (n % 30 == 0) begin
        fi = $urandom_range(62, 1);
        fj = $urandom_range(62, 1);
      end
      if (n % 50 == 0) no_idle = ($urandom_range(3) == 0);
      if (phase == 2 && n == 60) hold_len = 300;
      if (phase == 3 && n == 100) begin
        in_ch.valid = 0;
        while (pending != 0) @(negedge clk);
      end
      random_item();
    end
    no_idle = 0;
  endtask

  initial begin
    stencil_req_t s;
    int i, j, p;
    in_ch.valid = 0;
    s = cell_req(0, 0, 0, 0);
    in_ch.action = ACT_LOAD_CELL;
    in_ch.col_index = '0;
    in_ch.row_index = '0;
    in_ch.u_value = '0;
    in_ch.v_value = '0;
    in_ch.x_node = '0;
    in_ch.x_centre = '0;
    in_ch.y_node = '0;
    in_ch.y_centre = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    for (i = 0; i < 64; i++)
      send(coord_req(i, i, node_at(i), centre_at(i), node_at(i), centre_at(i)));
    for (i = 0; i < 5; i++)
      for (j = 0; j < 5; j++)
        send(cell_req(i, j, rand_vel(), rand_vel()));

    send(calc_req(1, 1));
    send(calc_req(2, 2));
    send(calc_req(3, 3));
    send(calc_req(0, 2));
    send(calc_req(2, 0));
    send(calc_req(63, 2));
    send(calc_req(2, 63));
    s = calc_req(2, 2);
    s.act = ACT_SPARE;
    send(s);
    send(cell_req(2, 2, Q_MAX, Q_MIN));
    send(calc_req(2, 2));
    send(calc_req(1, 2));
    send(calc_req(3, 2));
    send(cell_req(2, 2, '0, '0));
    send(calc_req(2, 2));
    send(coord_req(3, 3, node_at(2), centre_at(3), node_at(3), centre_at(2)));
    send(calc_req(3, 3));
    send(calc_req(2, 2));
    send(coord_req(4, 4, Q_MAX, Q_MIN, Q_MIN, Q_MAX));
    send(calc_req(3, 3));
    send(coord_req(3, 3, node_at(3), centre_at(3), node_at(3), centre_at(3)));
    send(coord_req(4, 4, node_at(4), centre_at(4), node_at(4), centre_at(4)));
    send(calc_req(3, 3));

    for (p = 0; p < 6; p++) begin
      drain();
      case (p)
        1: set_cfg('0, '1);
        2: set_cfg('1, '0);
        3: set_cfg('1, '1);
        4: set_cfg(CFG_W'($urandom_range(1 << 22, 1)), CFG_W'($urandom_range(1 << 22, 1)));
        5: set_cfg(CFG_W'($urandom), CFG_W'($urandom));
        default: ;
      endcase
      random_phase(200, p);
    end

    drain();
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
